// ===== hdl/uctrp_pkg.sv =====
// ----------------------------------------------------------------------------
// uctrp_pkg
// Shared types and TRB encoding constants for the control TRB ring producer.
// ----------------------------------------------------------------------------
package uctrp_pkg;

  // TRB type codes, placed in control[15:10]
  localparam int unsigned TypeShift = 10;
  localparam logic [5:0] TrbSetup  = 6'd2;
  localparam logic [5:0] TrbData   = 6'd3;
  localparam logic [5:0] TrbStatus = 6'd4;
  localparam logic [5:0] TrbLink   = 6'd6;

  localparam logic [31:0] CtlTypeSetup  = 32'(TrbSetup)  << TypeShift;
  localparam logic [31:0] CtlTypeData   = 32'(TrbData)   << TypeShift;
  localparam logic [31:0] CtlTypeStatus = 32'(TrbStatus) << TypeShift;
  localparam logic [31:0] CtlTypeLink   = 32'(TrbLink)   << TypeShift;

  localparam logic [31:0] CtlToggle = 32'h0000_0002;
  localparam logic [31:0] CtlIoc    = 32'h0000_0020;
  localparam logic [31:0] CtlIdt    = 32'h0000_0040;
  localparam logic [31:0] CtlDirIn  = 32'h0001_0000;

  // Transfer type field of the setup TRB, control[17:16]
  localparam int unsigned TrtShift = 16;
  localparam logic [1:0] TrtNone = 2'd0;
  localparam logic [1:0] TrtOut  = 2'd2;
  localparam logic [1:0] TrtIn   = 2'd3;

  localparam logic [31:0] SetupStatusLen = 32'd8;
  localparam logic [7:0]  DirBitMask     = 8'h80;

  // Decoded request, handed from front to back
  typedef struct packed {
    logic [63:0] packet;     // 8-byte setup packet
    logic [63:0] addr;
    logic [15:0] len;
    logic [1:0]  trt;
    logic        has_data;   // data TRB is written
    logic        data_in;    // data stage runs device-to-host
    logic        stat_in;    // status stage runs device-to-host
  } desc_t;

  typedef enum logic [1:0] {
    StepSetup,
    StepData,
    StepStatus
  } step_e;

endpackage

// ===== hdl/uctrp_front.sv =====
// ----------------------------------------------------------------------------
// uctrp_front
// Accepts control requests and decodes them into ring work descriptors.
// ----------------------------------------------------------------------------
module uctrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [7:0]         request_type_i,
  input  logic [7:0]         request_code_i,
  input  logic [15:0]        request_value_i,
  input  logic [15:0]        request_index_i,
  input  logic [15:0]        data_length_i,
  input  logic [63:0]        data_address_i,
  output logic               desc_valid_o,
  input  logic               desc_ready_i,
  output uctrp_pkg::desc_t   desc_o
);

  logic             valid_q, valid_d;
  uctrp_pkg::desc_t desc_q, desc_d;
  logic             accept;
  logic             is_in;
  logic             has_len;

  assign full_o = valid_q && !desc_ready_i;
  assign accept = push_i && !full_o;

  always_comb begin
    is_in   = (request_type_i & uctrp_pkg::DirBitMask) != 8'h00;
    has_len = data_length_i != 16'h0000;
    desc_d.packet   = {data_length_i, request_index_i, request_value_i,
                       request_code_i, request_type_i};
    desc_d.addr     = data_address_i;
    desc_d.len      = data_length_i;
    // transfer type follows the length alone, even if the address is zero
    desc_d.trt      = !has_len ? uctrp_pkg::TrtNone :
                      (is_in ? uctrp_pkg::TrtIn : uctrp_pkg::TrtOut);
    desc_d.has_data = has_len && (data_address_i != 64'h0);
    desc_d.data_in  = is_in;
    desc_d.stat_in  = !has_len || !is_in;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (desc_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  assign desc_valid_o = valid_q;
  assign desc_o       = desc_q;

endmodule

// ===== hdl/uctrp_fifo.sv =====
// ----------------------------------------------------------------------------
// uctrp_fifo
// Short descriptor queue between the decode front and the TRB sequencer.
// ----------------------------------------------------------------------------
module uctrp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  uctrp_pkg::desc_t   wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_pop_i,
  output uctrp_pkg::desc_t   rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  uctrp_pkg::desc_t      mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign wr_ready_o = cnt_q != CntW'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hdl/uctrp_back.sv =====
// ----------------------------------------------------------------------------
// uctrp_back
// TRB sequencer: expands descriptors into ring writes, tracks write position
// and producer cycle, and inserts link TRBs at the end of the ring.
// ----------------------------------------------------------------------------
module uctrp_back #(
  parameter int unsigned RING_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [63:0]        ring_base_i,
  input  logic               desc_valid_i,
  input  uctrp_pkg::desc_t   desc_i,
  output logic               desc_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [7:0]         trb_position_o,
  output logic [63:0]        trb_param_o,
  output logic [31:0]        trb_status_o,
  output logic [31:0]        trb_control_o,
  output logic               last_trb_o
);

  localparam int unsigned PosW = $clog2(RING_ENTRIES);
  localparam logic [PosW-1:0] LinkPos = PosW'(RING_ENTRIES - 1);
  localparam logic [PosW-1:0] PrePos  = PosW'(RING_ENTRIES - 2);

  uctrp_pkg::step_e step_q, step_d;
  logic             link_pend_q, link_pend_d;
  logic             link_last_q, link_last_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             cycle_q, cycle_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       pos_out_q;
  logic [63:0]      param_q;
  logic [31:0]      status_q;
  logic [31:0]      control_q;
  logic             last_q;

  logic             emit;
  logic             wrap;
  logic [PosW+7:0]  pos_ext;
  logic [63:0]      param_d;
  logic [31:0]      status_d;
  logic [31:0]      control_d;
  logic             last_d;

  // one beat per cycle while a descriptor is waiting and the output register drains or is empty
  assign emit    = desc_valid_i && (!out_valid_q || pop_i);
  assign wrap    = !link_pend_q && (pos_q == PrePos);
  assign pos_ext = {8'h00, pos_q};

  // next state
  always_comb begin
    step_d      = step_q;
    link_pend_d = link_pend_q;
    link_last_d = link_last_q;
    pos_d       = pos_q;
    cycle_d     = cycle_q;
    desc_pop_o  = 1'b0;
    if (emit) begin
      if (link_pend_q) begin
        link_pend_d = 1'b0;
        pos_d       = '0;
        cycle_d     = !cycle_q;
        desc_pop_o  = link_last_q;
      end else begin
        pos_d       = pos_q + 1'b1;
        link_pend_d = wrap;
        link_last_d = step_q == uctrp_pkg::StepStatus;
        unique case (step_q)
          uctrp_pkg::StepSetup: begin
            step_d = desc_i.has_data ? uctrp_pkg::StepData : uctrp_pkg::StepStatus;
          end
          uctrp_pkg::StepData: begin
            step_d = uctrp_pkg::StepStatus;
          end
          uctrp_pkg::StepStatus: begin
            step_d     = uctrp_pkg::StepSetup;
            desc_pop_o = !wrap;
          end
          default: begin
            step_d = uctrp_pkg::StepSetup;
          end
        endcase
      end
    end
  end

  // TRB contents for the beat being built
  always_comb begin
    param_d   = 64'h0;
    status_d  = 32'h0;
    control_d = {31'h0, cycle_q};
    last_d    = 1'b0;
    if (link_pend_q) begin
      param_d   = ring_base_i;
      control_d = uctrp_pkg::CtlTypeLink | uctrp_pkg::CtlToggle | {31'h0, cycle_q};
      last_d    = link_last_q;
    end else begin
      unique case (step_q)
        uctrp_pkg::StepSetup: begin
          param_d   = desc_i.packet;
          status_d  = uctrp_pkg::SetupStatusLen;
          control_d = uctrp_pkg::CtlTypeSetup | uctrp_pkg::CtlIdt
                    | (32'(desc_i.trt) << uctrp_pkg::TrtShift) | {31'h0, cycle_q};
        end
        uctrp_pkg::StepData: begin
          param_d   = desc_i.addr;
          status_d  = {16'h0, desc_i.len};
          control_d = uctrp_pkg::CtlTypeData | {31'h0, cycle_q}
                    | (desc_i.data_in ? uctrp_pkg::CtlDirIn : 32'h0);
        end
        uctrp_pkg::StepStatus: begin
          control_d = uctrp_pkg::CtlTypeStatus | uctrp_pkg::CtlIoc | {31'h0, cycle_q}
                    | (desc_i.stat_in ? uctrp_pkg::CtlDirIn : 32'h0);
          // a link right after the status beat carries the last flag instead
          last_d    = !wrap;
        end
        default: begin
          control_d = {31'h0, cycle_q};
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= uctrp_pkg::StepSetup;
      link_pend_q <= 1'b0;
      link_last_q <= 1'b0;
      pos_q       <= '0;
      cycle_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      link_pend_q <= link_pend_d;
      link_last_q <= link_last_d;
      pos_q       <= pos_d;
      cycle_q     <= cycle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pos_out_q <= pos_ext[7:0];
      param_q   <= param_d;
      status_q  <= status_d;
      control_q <= control_d;
      last_q    <= last_d;
    end
  end

  assign empty_o        = !out_valid_q;
  assign trb_position_o = pos_out_q;
  assign trb_param_o    = param_q;
  assign trb_status_o   = status_q;
  assign trb_control_o  = control_q;
  assign last_trb_o     = last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LinkPos)
    else $error("write position beyond ring end");

  a_link_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_pend_q |-> pos_q == LinkPos)
    else $error("link pending away from last entry");

  a_link_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && link_pend_q) |=> (pos_q == '0) && (cycle_q != $past(cycle_q)))
    else $error("link beat did not wrap position and flip cycle");

  a_pop_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |=> out_valid_q && last_q)
    else $error("descriptor retired without a last beat");

endmodule

// ===== hdl/usb_control_trb_ring_producer_unit.sv =====
// ----------------------------------------------------------------------------
// usb_control_trb_ring_producer_unit
// Turns USB control requests into xHCI transfer-ring TRB writes.
//
//   channel   direction  handshake          payload
//   request   in         push_i / full_o    request_*_i, data_*_i
//   trb       out        empty_o / pop_i    trb_*_o, last_trb_o
//   config    in         cfg_we_i           cfg_wdata_i (ring base address)
//
// Each request yields 2 or 3 TRB beats (setup, data when length and address
// are both nonzero, status), plus one link beat when the ring wraps; one beat
// per cycle from the back sequencer's output reg while the consumer pops it.
// A request's first beat passes the front register, the two-entry descriptor
// queue and the back output reg; while the consumer stalls the sequencer,
// requests are taken until queue and front fill. Reset: position 0, cycle bit 1.
// ----------------------------------------------------------------------------
module usb_control_trb_ring_producer_unit #(
  parameter int unsigned RING_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_index_i,
  input  logic [15:0] data_length_i,
  input  logic [63:0] data_address_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  trb_position_o,
  output logic [63:0] trb_param_o,
  output logic [31:0] trb_status_o,
  output logic [31:0] trb_control_o,
  output logic        last_trb_o
);

  logic [63:0]      ring_base_q;
  logic             fr_valid;
  logic             fr_ready;
  uctrp_pkg::desc_t fr_desc;
  logic             q_valid;
  logic             q_pop;
  uctrp_pkg::desc_t q_desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_base_q <= 64'h0;
    end else if (cfg_we_i) begin
      ring_base_q <= cfg_wdata_i;
    end
  end

  uctrp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_o          (full_o),
    .request_type_i  (request_type_i),
    .request_code_i  (request_code_i),
    .request_value_i (request_value_i),
    .request_index_i (request_index_i),
    .data_length_i   (data_length_i),
    .data_address_i  (data_address_i),
    .desc_valid_o    (fr_valid),
    .desc_ready_i    (fr_ready),
    .desc_o          (fr_desc)
  );

  uctrp_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_desc),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_data_o  (q_desc)
  );

  uctrp_back #(
    .RING_ENTRIES (RING_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ring_base_i    (ring_base_q),
    .desc_valid_i   (q_valid),
    .desc_i         (q_desc),
    .desc_pop_o     (q_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .trb_position_o (trb_position_o),
    .trb_param_o    (trb_param_o),
    .trb_status_o   (trb_status_o),
    .trb_control_o  (trb_control_o),
    .last_trb_o     (last_trb_o)
  );

endmodule
